/* rtl/i2c_master_bit_engine_core_macros.svh */
// ---------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion forms, clocked on clk and reset on rst_n.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define I2CMB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cmb same-cycle check failed");

// Next-cycle implication.
`define I2CMB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmb next-cycle check failed");

`endif

/* rtl/i2cmb_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine package
// Command and status codes, transfer payload types and helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cmb_pkg;

    localparam int HOLD_W = 10;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd10;
    localparam logic [2:0] BIT_TOP = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_RESTART = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_WRITE   = 3'd4,
        CMD_READ    = 3'd5,
        CMD_WAITACK = 3'd6,
        CMD_SENDACK = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_BUSY = 2'd1,
        ST_NO_ACK   = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       sda_level;
        logic       bus_free;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } res_t;

    // Index of the final phase of each command's sequence.
    function automatic logic [1:0] last_phase(input cmd_t cmd);
        logic [1:0] lp;
        unique case (cmd)
            CMD_STOP:                           lp = 2'd0;
            CMD_START, CMD_RESTART:             lp = 2'd1;
            CMD_WRITE, CMD_READ, CMD_WAITACK:   lp = 2'd2;
            CMD_NONE, CMD_SENDACK:              lp = 2'd3;
        endcase
        return lp;
    endfunction

    // A hold of zero behaves as one tick.
    function automatic logic [HOLD_W-1:0] eff_hold(input logic [HOLD_W-1:0] hold);
        return (hold == '0) ? HOLD_W'(1) : hold;
    endfunction

endpackage

`default_nettype wire

/* rtl/i2cmb_if.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine channel interfaces
// Tick, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface i2cmb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       sda_level;
    logic       bus_free;

    modport source (output valid, mode, data_byte, sda_level, bus_free, input ready);
    modport sink   (input valid, mode, data_byte, sda_level, bus_free, output ready);
endinterface

interface i2cmb_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;

    modport source (output valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                    input ready);
    modport sink   (input valid, scl_out, sda_out, busy_res, done_res, status, read_data,
                    output ready);
endinterface

interface i2cmb_cfg_if;
    logic       valid;
    logic       ready;
    logic [9:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_master_bit_engine_core.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine core
// Tick-driven bit-level I2C master: sequences SCL/SDA phases per command.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                            | transfer
//  in_ch    | in  | mode, data_byte, sda_level, bus_free (one tick)    | valid & ready
//  out_ch   | out | scl_out, sda_out, busy_res, done_res, status,      | valid & ready
//           |     | read_data (one result per tick)                    |
//  cfg      | in  | data = hold_ticks                                  | valid & ready
//
//  One tick is taken per cycle while in_ch.ready is high; its result is
//  registered in the result buffer and shows on out_ch. The sequencer state
//  update is a single pass of logic. A two-entry result buffer lets in_ch keep
//  flowing while out_ch stalls; in_ch.ready drops only when both entries are full.
//  rst_n clears the sequencer to idle, pins released, hold_ticks to 10.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    i2cmb_in_if.sink      in_ch,
    i2cmb_out_if.source   out_ch,
    i2cmb_cfg_if.sink     cfg
);

    logic [i2cmb_pkg::HOLD_W-1:0] hold_reg;
    i2cmb_pkg::item_t             item;
    i2cmb_pkg::res_t              res;
    i2cmb_pkg::res_t              out_data;
    logic                         space;
    logic                         step;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= i2cmb_pkg::HOLD_RESET;
        else if (cfg.valid)
            hold_reg <= cfg.data;
    end

    assign item.mode      = in_ch.mode;
    assign item.data_byte = in_ch.data_byte;
    assign item.sda_level = in_ch.sda_level;
    assign item.bus_free  = in_ch.bus_free;

    assign in_ch.ready = space;
    assign step        = in_ch.valid && space;

    i2cmb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item),
        .hold  (hold_reg),
        .res   (res)
    );

    i2cmb_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .res       (res),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.scl_out   = out_data.scl_out;
    assign out_ch.sda_out   = out_data.sda_out;
    assign out_ch.busy_res  = out_data.busy_res;
    assign out_ch.done_res  = out_data.done_res;
    assign out_ch.status    = out_data.status;
    assign out_ch.read_data = out_data.read_data;

endmodule

`default_nettype wire

/* rtl/i2cmb_seq.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine phase sequencer
// Holds the command state and computes pin levels and status for each tick.
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_bit_engine_core_macros.svh"

module i2cmb_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire i2cmb_pkg::item_t           item,
    input  wire logic [i2cmb_pkg::HOLD_W-1:0] hold,
    output i2cmb_pkg::res_t                 res
);

    i2cmb_pkg::cmd_t                cmd_reg, cmd_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [2:0]                     bit_reg, bit_next;
    logic [i2cmb_pkg::HOLD_W-1:0]   hold_cnt_reg, hold_cnt_next;
    logic [7:0]                     shift_reg, shift_next;
    logic                           scl_reg, scl_next;
    logic                           sda_reg, sda_next;
    logic [1:0]                     status_reg, status_next;
    logic [7:0]                     rdata_reg, rdata_next;
    logic                           ack_reg, ack_next;
    logic                           busy;
    logic                           done;
    logic                           enter;

    always_comb
    begin
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        hold_cnt_next = hold_cnt_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        status_next   = status_reg;
        rdata_next    = rdata_reg;
        ack_next      = ack_reg;
        busy          = 1'b0;
        done          = 1'b0;
        enter         = 1'b0;

        if (cmd_reg == i2cmb_pkg::CMD_NONE)
        begin
            if (i2cmb_pkg::cmd_t'(item.mode) == i2cmb_pkg::CMD_START && !item.bus_free)
            begin
                status_next = i2cmb_pkg::ST_BUS_BUSY;
                done        = 1'b1;
            end
            else if (i2cmb_pkg::cmd_t'(item.mode) != i2cmb_pkg::CMD_NONE)
            begin
                cmd_next   = i2cmb_pkg::cmd_t'(item.mode);
                phase_next = 2'd0;
                bit_next   = i2cmb_pkg::BIT_TOP;
                ack_next   = 1'b0;
                if (i2cmb_pkg::cmd_t'(item.mode) == i2cmb_pkg::CMD_WRITE)
                begin
                    shift_next = item.data_byte;
                end
                enter = 1'b1;
                busy  = 1'b1;
            end
        end
        else if (hold_cnt_reg > i2cmb_pkg::HOLD_W'(1))
        begin
            hold_cnt_next = hold_cnt_reg - i2cmb_pkg::HOLD_W'(1);
            busy          = 1'b1;
        end
        else if (phase_reg < i2cmb_pkg::last_phase(cmd_reg))
        begin
            phase_next = phase_reg + 2'd1;
            enter      = 1'b1;
            busy       = 1'b1;
        end
        else if ((cmd_reg == i2cmb_pkg::CMD_WRITE || cmd_reg == i2cmb_pkg::CMD_READ) &&
                 bit_reg != 3'd0)
        begin
            // Loop back for the next bit, MSB first.
            bit_next   = bit_reg - 3'd1;
            phase_next = (cmd_reg == i2cmb_pkg::CMD_WRITE) ? 2'd0 : 2'd1;
            enter      = 1'b1;
            busy       = 1'b1;
        end
        else
        begin
            if (cmd_reg == i2cmb_pkg::CMD_START || cmd_reg == i2cmb_pkg::CMD_RESTART)
            begin
                scl_next = 1'b0;
            end
            if (cmd_reg == i2cmb_pkg::CMD_STOP || cmd_reg == i2cmb_pkg::CMD_WRITE ||
                cmd_reg == i2cmb_pkg::CMD_SENDACK)
            begin
                sda_next = 1'b1;
            end
            status_next   = (cmd_reg == i2cmb_pkg::CMD_WAITACK && ack_reg) ?
                            i2cmb_pkg::ST_NO_ACK : i2cmb_pkg::ST_OK;
            cmd_next      = i2cmb_pkg::CMD_NONE;
            phase_next    = 2'd0;
            bit_next      = i2cmb_pkg::BIT_TOP;
            hold_cnt_next = '0;
            done          = 1'b1;
        end

        // Apply the levels of the phase being entered.
        if (enter)
        begin
            unique case (cmd_next)
                i2cmb_pkg::CMD_START, i2cmb_pkg::CMD_RESTART:
                begin
                    if (phase_next == 2'd0)
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next = 1'b0;
                    end
                end
                i2cmb_pkg::CMD_STOP:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                i2cmb_pkg::CMD_WRITE:
                begin
                    if (phase_next == 2'd0)
                        sda_next = shift_next[bit_next];
                    else
                        scl_next = (phase_next == 2'd1);
                end
                i2cmb_pkg::CMD_READ:
                begin
                    if (phase_next == 2'd0)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (phase_next == 2'd1)
                    begin
                        scl_next             = 1'b1;
                        rdata_next[bit_next] = item.sda_level;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cmb_pkg::CMD_WAITACK:
                begin
                    if (phase_next == 2'd0)
                        sda_next = 1'b1;
                    else
                        scl_next = (phase_next == 2'd1);
                end
                i2cmb_pkg::CMD_SENDACK:
                begin
                    if (phase_next == 2'd0)
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (phase_next == 2'd1)
                    begin
                        sda_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = (phase_next == 2'd2);
                    end
                end
                i2cmb_pkg::CMD_NONE:
                begin
                end
            endcase
            hold_cnt_next = i2cmb_pkg::eff_hold(hold);
        end

        // Keep the last SDA sample seen while SCL is high for wait-ack.
        if (busy && cmd_next == i2cmb_pkg::CMD_WAITACK && phase_next == 2'd1)
        begin
            ack_next = item.sda_level;
        end
    end

    always_comb
    begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.busy_res  = busy;
        res.done_res  = done;
        res.status    = status_next;
        res.read_data = rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= i2cmb_pkg::CMD_NONE;
            phase_reg    <= 2'd0;
            bit_reg      <= i2cmb_pkg::BIT_TOP;
            hold_cnt_reg <= '0;
            shift_reg    <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            status_reg   <= i2cmb_pkg::ST_OK;
            rdata_reg    <= 8'd0;
            ack_reg      <= 1'b0;
        end
        else if (step)
        begin
            cmd_reg      <= cmd_next;
            phase_reg    <= phase_next;
            bit_reg      <= bit_next;
            hold_cnt_reg <= hold_cnt_next;
            shift_reg    <= shift_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            status_reg   <= status_next;
            rdata_reg    <= rdata_next;
            ack_reg      <= ack_next;
        end
    end

    `I2CMB_ASSERT_IMPL(a_active_hold_nonzero, cmd_reg != i2cmb_pkg::CMD_NONE, hold_cnt_reg != '0)
    `I2CMB_ASSERT_NEXT(a_idle_stays_idle,
        step && cmd_reg == i2cmb_pkg::CMD_NONE &&
        i2cmb_pkg::cmd_t'(item.mode) == i2cmb_pkg::CMD_NONE,
        cmd_reg == i2cmb_pkg::CMD_NONE)
    `I2CMB_ASSERT_NEXT(a_finish_rewinds,
        step && done && cmd_reg != i2cmb_pkg::CMD_NONE,
        cmd_reg == i2cmb_pkg::CMD_NONE && phase_reg == 2'd0 && bit_reg == i2cmb_pkg::BIT_TOP)

endmodule

`default_nettype wire

/* rtl/i2cmb_out_buf.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine result buffer
// Two-entry output register with skid slot between the sequencer and the sink.
// ---------------------------------------------------------------------------
`default_nettype none
`include "i2c_master_bit_engine_core_macros.svh"

module i2cmb_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire i2cmb_pkg::res_t res,
    output logic                 space,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output i2cmb_pkg::res_t      out_data
);

    logic            v0_reg;
    logic            v1_reg;
    i2cmb_pkg::res_t d0_reg;
    i2cmb_pkg::res_t d1_reg;
    logic            pop;

    assign pop       = v0_reg && out_ready;
    assign space     = !v1_reg;
    assign out_valid = v0_reg;
    assign out_data  = d0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (v1_reg)
            begin
                v1_reg <= push;
            end
            else
            begin
                v0_reg <= push;
            end
        end
        else if (!v0_reg)
        begin
            v0_reg <= push;
        end
        else if (push)
        begin
            v1_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (v1_reg)
            begin
                d0_reg <= d1_reg;
                if (push)
                    d1_reg <= res;
            end
            else if (push)
            begin
                d0_reg <= res;
            end
        end
        else if (!v0_reg)
        begin
            if (push)
                d0_reg <= res;
        end
        else if (push)
        begin
            // Head is stalled: park the transfer in the skid slot.
            d1_reg <= res;
        end
    end

    `I2CMB_ASSERT_IMPL(a_skid_needs_head, v1_reg, v0_reg)
    `I2CMB_ASSERT_NEXT(a_drain_empties, pop && !v1_reg && !push, !v0_reg)
    `I2CMB_ASSERT_NEXT(a_fill_head, push && !v0_reg, v0_reg && d0_reg == $past(res))

endmodule

`default_nettype wire
